// ----- hw/rtl/nip_pkg.sv -----
// Package for the NEC infrared pulse decoder: opcode and phase codes, nominal
// pulse durations, the decoder state and item/result types, and the duration match.
// No dependencies.
`default_nettype none

package nip_pkg;

  localparam int FRAME_BYTES = 4;
  localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);

  localparam logic [1:0] OP_PULSE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_LEADER  = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_DONE    = 3'd3;
  localparam logic [2:0] PH_ENDED   = 3'd4;
  localparam logic [2:0] PH_INVALID = 3'd5;

  localparam logic [15:0] LEADER_LOW_US  = 16'd9000;
  localparam logic [15:0] LEADER_HIGH_US = 16'd4500;
  localparam logic [15:0] BIT_SHORT_US   = 16'd560;
  localparam logic [15:0] BIT_LONG_US    = 16'd1680;
  localparam logic [15:0] TOL_RESET      = 16'd300;

  localparam logic [7:0] NO_FRAME_BYTE = 8'hFF;
  localparam logic [8:0] COMPLEMENT_SUM = 9'd255;

  localparam logic [1:0] REG_ADDR_TOL = 2'd0;

  typedef struct packed {
    logic [2:0]                  phase;
    logic [15:0]                 last_low;
    logic [FRAME_BYTES-1:0][7:0] payload;
    logic [2:0]                  bit_count;
    logic [2:0]                  byte_count;
  } nip_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        pulse_level;
    logic [15:0] pulse_length;
  } nip_item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [7:0]  address_byte;
    logic [7:0]  command_byte;
    logic [2:0]  phase;
  } nip_result_t;

  // True when the measured duration lies strictly within tol of the nominal one.
  function automatic logic near_match(input logic [15:0] nominal,
                                      input logic [15:0] measured,
                                      input logic [15:0] tol);
    logic [15:0] diff;
    diff = (nominal > measured) ? (nominal - measured) : (measured - nominal);
    return diff < tol;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nip_cfg.sv -----
// APB-style register port for the NEC decoder: holds the match tolerance.
// Depends on nip_pkg.
`default_nettype none

module nip_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      tolerance
);

  logic wr_tol;

  assign pready = 1'b1;
  assign wr_tol = psel && penable && pwrite && (paddr == nip_pkg::REG_ADDR_TOL);

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= nip_pkg::TOL_RESET;
    end else if (wr_tol) begin
      tolerance <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == nip_pkg::REG_ADDR_TOL) begin
      prdata = {16'd0, tolerance};
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nip_step.sv -----
// Next-state and result logic of the NEC decoder for one registered item.
// Depends on nip_pkg.
`default_nettype none

module nip_step (
  input  wire nip_pkg::nip_state_t  cur,
  input  wire nip_pkg::nip_item_t   item,
  input  wire logic [15:0]          tolerance,
  output nip_pkg::nip_state_t       nxt,
  output nip_pkg::nip_result_t      res
);

  logic low_ok;
  logic zero_ok;
  logic one_ok;
  logic leader_ok;
  logic check_ok;
  logic [2:0] byte_inc;

  assign low_ok    = nip_pkg::near_match(nip_pkg::BIT_SHORT_US, cur.last_low, tolerance);
  assign zero_ok   = low_ok &&
                     nip_pkg::near_match(nip_pkg::BIT_SHORT_US, item.pulse_length, tolerance);
  assign one_ok    = low_ok &&
                     nip_pkg::near_match(nip_pkg::BIT_LONG_US, item.pulse_length, tolerance);
  assign leader_ok = nip_pkg::near_match(nip_pkg::LEADER_LOW_US, cur.last_low, tolerance) &&
                     nip_pkg::near_match(nip_pkg::LEADER_HIGH_US, item.pulse_length,
                                         tolerance);
  assign check_ok  = (cur.phase == nip_pkg::PH_ENDED) &&
                     ({1'b0, cur.payload[0]} + {1'b0, cur.payload[1]} ==
                      nip_pkg::COMPLEMENT_SUM) &&
                     ({1'b0, cur.payload[2]} + {1'b0, cur.payload[3]} ==
                      nip_pkg::COMPLEMENT_SUM);
  assign byte_inc  = cur.byte_count + 3'd1;

  always_comb begin
    nxt = cur;
    res.frame_valid  = 1'b0;
    res.address_byte = nip_pkg::NO_FRAME_BYTE;
    res.command_byte = nip_pkg::NO_FRAME_BYTE;

    case (item.opcode)
      nip_pkg::OP_PULSE: begin
        if (cur.phase == nip_pkg::PH_INVALID) begin
          nxt.phase = nip_pkg::PH_INVALID;
        end else if (cur.phase == nip_pkg::PH_ENDED) begin
          nxt.phase = nip_pkg::PH_INVALID;
        end else if (!item.pulse_level) begin
          if (cur.phase == nip_pkg::PH_DONE) begin
            nxt.phase = nip_pkg::PH_ENDED;
          end else begin
            nxt.last_low = item.pulse_length;
          end
        end else if (cur.phase == nip_pkg::PH_IDLE) begin
          nxt.phase = leader_ok ? nip_pkg::PH_LEADER : nip_pkg::PH_INVALID;
        end else if (cur.phase inside {nip_pkg::PH_LEADER, nip_pkg::PH_DATA}) begin
          nxt.phase = nip_pkg::PH_DATA;
          // A pair that is neither a zero nor a one still uses up a bit slot.
          for (int i = 0; i < nip_pkg::FRAME_BYTES; i++) begin
            if (cur.byte_count == 3'(i)) begin
              if (zero_ok) begin
                nxt.payload[i] = {1'b0, cur.payload[i][7:1]};
              end else if (one_ok) begin
                nxt.payload[i] = {1'b1, cur.payload[i][7:1]};
              end
            end
          end
          if (cur.bit_count == 3'd7) begin
            nxt.bit_count  = 3'd0;
            nxt.byte_count = byte_inc;
            if (byte_inc >= 3'(nip_pkg::FRAME_BYTES)) begin
              nxt.phase = nip_pkg::PH_DONE;
            end
          end else begin
            nxt.bit_count = cur.bit_count + 3'd1;
          end
        end else begin
          nxt.phase = nip_pkg::PH_INVALID;
        end
      end
      nip_pkg::OP_QUERY: begin
        if (check_ok) begin
          res.frame_valid  = 1'b1;
          res.address_byte = cur.payload[0];
          res.command_byte = cur.payload[2];
          nxt = '0;
        end
      end
      nip_pkg::OP_CLEAR: begin
        nxt = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase

    res.phase = nxt.phase;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nec_ir_pulse_decoder.sv -----
// Top level of the NEC infrared pulse decoder: input register, decoder state,
// result register and the register port. Depends on nip_pkg, nip_cfg, nip_step.
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   opcode, pulse_level, pulse_length
// result    out        out_valid / out_stall frame_valid, address_byte, command_byte, phase
// config    in         psel/penable/pready   paddr, pwdata, prdata (match tolerance)
//
// Every accepted item produces exactly one result transfer: it passes through the input
// register and then the result register. A new item can be taken every cycle while the
// result side is not stalled: the combinational step logic between the input register
// and the result register sets that rate. A stall on the result side holds the result
// register and, once the input register is also full, raises in_stall. rst is synchronous
// and clears the decoder state, both valid flags and the tolerance (back to 300 us).

module nec_ir_pulse_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic        pulse_level,
  input  wire logic [15:0] pulse_length,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             frame_valid,
  output logic [7:0]       address_byte,
  output logic [7:0]       command_byte,
  output logic [2:0]       phase,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                 item_valid;
  nip_pkg::nip_item_t   item;
  nip_pkg::nip_state_t  state;
  nip_pkg::nip_state_t  state_next;
  nip_pkg::nip_result_t step_res;
  nip_pkg::nip_result_t res;
  logic [15:0]          tolerance;
  logic                 advance;
  logic                 take_in;

  // The result register can load when it is empty or its transfer completes now.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;
  assign take_in  = in_valid && !in_stall;

  nip_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tolerance (tolerance)
  );

  nip_step u_step (
    .cur       (state),
    .item      (item),
    .tolerance (tolerance),
    .nxt       (state_next),
    .res       (step_res)
  );

  // Input register: the item waits here until the result register has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take_in) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      item.opcode       <= opcode;
      item.pulse_level  <= pulse_level;
      item.pulse_length <= pulse_length;
    end
  end

  // Decoder state moves only when an item passes into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (item_valid && advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      res <= step_res;
    end
  end

  assign frame_valid  = res.frame_valid;
  assign address_byte = res.address_byte;
  assign command_byte = res.command_byte;
  assign phase        = res.phase;

endmodule

`default_nettype wire

// ----- hw/rtl/nip_checker.sv -----
// Port-level checks for the NEC decoder, bound to its top level.
// Depends on nip_pkg and nec_ir_pulse_decoder.
`default_nettype none

module nip_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       frame_valid,
  input wire logic [7:0] address_byte,
  input wire logic [7:0] command_byte,
  input wire logic [2:0] phase
);

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_valid) &&
    $stable(address_byte) && $stable(command_byte) && $stable(phase))
    else $error("result changed while stalled");

  // A decoded frame clears the decoder.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_valid |-> phase == nip_pkg::PH_IDLE)
    else $error("decoded frame did not return to idle");

  // Without a frame both bytes carry the marker.
  a_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_valid |->
    address_byte == nip_pkg::NO_FRAME_BYTE && command_byte == nip_pkg::NO_FRAME_BYTE)
    else $error("bytes set without a decoded frame");

  // Phase codes stay within the defined set.
  a_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> phase <= nip_pkg::PH_INVALID)
    else $error("phase out of range");

endmodule

bind nec_ir_pulse_decoder nip_checker u_nip_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .frame_valid  (frame_valid),
  .address_byte (address_byte),
  .command_byte (command_byte),
  .phase        (phase)
);

`default_nettype wire
